/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define VQCB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define VQCB_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/vqcb_pkg.sv */
package vqcb_pkg;

    localparam int DESC_W  = 8;
    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 32;
    localparam int RDBL_W  = 5;
    localparam int AVAIL_W = 16;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    localparam int DEF_MAX_QUEUE = 256;
    localparam int DEF_MAX_CHAIN = 16;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_RETURN = 1'b1;

    localparam logic [1:0] KIND_DESC   = 2'd0;
    localparam logic [1:0] KIND_RING   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TOO_BIG  = 3'd1;
    localparam logic [2:0] ST_NO_FREE  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] buf_addr;
        logic [LEN_W-1:0]  buf_len;
        logic [RDBL_W-1:0] readable_count;
        logic              chain_last;
        logic [DESC_W-1:0] desc_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [DESC_W-1:0]  slot;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   len;
        logic [1:0]         flags;
        logic [DESC_W-1:0]  next_slot;
        logic [AVAIL_W-1:0] avail_index;
        logic [2:0]         status;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
    } t_chain_ent;

endpackage

/* sv/vqcb_free_stack.sv */
`include "assert_macros.svh"

module vqcb_free_stack
    import vqcb_pkg::*;
#(
    parameter int MAX_QUEUE = DEF_MAX_QUEUE,
    localparam int AW  = $clog2(MAX_QUEUE),
    localparam int FCW = $clog2(MAX_QUEUE + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_init,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DESC_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DESC_W-1:0] o_rd_data
);

    logic [DESC_W-1:0] mem [MAX_QUEUE];
    logic [DESC_W-1:0] r_rd_data;
    logic [AW-1:0]     r_rd_addr;
    logic              r_use_init;
    // entries below the mark were not written since init and hold their own index
    logic [FCW-1:0]    r_mark;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_rd_addr  <= i_rd_addr;
            r_use_init <= (FCW'(i_rd_addr) < r_mark);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_mark <= FCW'(MAX_QUEUE);
        end else if (i_wr_en && (FCW'(i_wr_addr) < r_mark)) begin
            r_mark <= FCW'(i_wr_addr);
        end
    end

    assign o_rd_data = r_use_init ? DESC_W'(r_rd_addr) : r_rd_data;

    `VQCB_NEVER(a_stk_rw_overlap, i_clk, i_rst_n, i_rd_en && i_wr_en, "stack read and write collide")

endmodule

/* sv/vqcb_chain_mem.sv */
`include "assert_macros.svh"

module vqcb_chain_mem
    import vqcb_pkg::*;
#(
    parameter int MAX_CHAIN = DEF_MAX_CHAIN,
    localparam int IW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_wr_en,
    input  logic [IW-1:0] i_wr_idx,
    input  t_chain_ent i_wr_data,
    input  logic       i_rd_en,
    input  logic [IW-1:0] i_rd_idx,
    output t_chain_ent o_rd_data
);

    t_chain_ent mem [MAX_CHAIN];
    t_chain_ent r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

    `VQCB_NEVER(a_chain_rw_overlap, i_clk, i_rst_n, i_rd_en && i_wr_en, "chain read during collect")

endmodule

/* sv/virtqueue_chain_builder_top.sv */
// channel   | handshake                      | payload
// ----------+--------------------------------+------------------------
// command   | start, busy (accept: start&!busy) | i_item (t_in_item)
// result    | o_strobe, one cycle, no stall  | o_result (t_out_item)
// config    | i_cfg_valid, o_cfg_ready       | i_cfg_data (queue_size_log2)
//
// a buffer that is not last and a return command are taken in idle and leave busy low
// a return or rejected chain gives its status in the cycle after the transfer
// an accepted chain of n buffers holds busy through the stack and chain
// memory prefetch, one descriptor write per cycle, then the ring write
// synchronous reset, no clearing pass: a fill mark stands in for the initial stack
// results cannot be stalled; config is taken only while busy and start are low

`include "assert_macros.svh"

module virtqueue_chain_builder_top
    import vqcb_pkg::*;
#(
    parameter int MAX_QUEUE = DEF_MAX_QUEUE,
    parameter int MAX_CHAIN = DEF_MAX_CHAIN
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_item         i_item,
    output logic             o_strobe,
    output t_out_item        o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW   = $clog2(MAX_QUEUE);
    localparam int FCW  = $clog2(MAX_QUEUE + 1);
    localparam int CW   = $clog2(MAX_CHAIN + 2);
    localparam int IW   = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
    localparam int TOTW = LEN_W + $clog2(MAX_CHAIN + 1);
    localparam int HIW  = TOTW - LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_DESC,
        S_RING
    } t_state;

    function automatic logic [FCW-1:0] f_qsize(input logic [CFG_W-1:0] lg);
        int s;
        s = 1 << lg;
        if (s > MAX_QUEUE) begin
            s = MAX_QUEUE;
        end
        return FCW'(s);
    endfunction

    t_state             r_state, n_state;
    logic [FCW-1:0]     r_qsize, n_qsize;
    logic [FCW-1:0]     r_free, n_free;
    logic [FCW-1:0]     r_base, n_base;
    logic [AVAIL_W-1:0] r_avail, n_avail;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [TOTW-1:0]    r_total, n_total;
    logic [RDBL_W-1:0]  r_rdbl, n_rdbl;
    logic [RDBL_W-1:0]  r_erd, n_erd;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_i, n_i;
    logic [DESC_W-1:0]  r_head, n_head;
    logic [DESC_W-1:0]  r_cur_desc, n_cur_desc;
    t_chain_ent         r_cur_ent, n_cur_ent;
    t_out_item          r_out, n_out;
    logic               r_strobe, n_strobe;

    logic              stk_init;
    logic              stk_wr_en;
    logic [AW-1:0]     stk_wr_addr;
    logic [DESC_W-1:0] stk_wr_data;
    logic              stk_rd_en;
    logic [AW-1:0]     stk_rd_addr;
    logic [DESC_W-1:0] stk_rd_data;

    logic              ch_wr_en;
    logic [IW-1:0]     ch_wr_idx;
    logic              ch_rd_en;
    logic [IW-1:0]     ch_rd_idx;
    t_chain_ent        ch_wr_data;
    t_chain_ent        ch_rd_data;

    logic              accept;
    logic              cfg_wr;
    logic [CW-1:0]     cnt_new;
    logic [TOTW-1:0]   total_new;
    logic [RDBL_W-1:0] rd_eff;
    logic              too_big;
    logic              has_next;
    logic [CW:0]       idx2;
    logic [FCW-1:0]    pop_addr;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy && !start;
    assign accept      = start && !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    assign ch_wr_data.addr = i_item.buf_addr;
    assign ch_wr_data.len  = i_item.buf_len;
    assign stk_wr_data     = i_item.desc_index;

    assign rd_eff    = (r_cnt == '0) ? i_item.readable_count : r_rdbl;
    assign cnt_new   = (32'(r_cnt) < MAX_CHAIN) ? r_cnt + CW'(1) : CW'(MAX_CHAIN + 1);
    assign total_new = r_total + TOTW'(i_item.buf_len);
    assign too_big   = (total_new[TOTW-1:LEN_W] > HIW'(1))
                    || ((total_new[TOTW-1:LEN_W] == HIW'(1)) && (total_new[LEN_W-1:0] != '0));
    assign has_next  = ({1'b0, r_i} + (CW+1)'(1)) < {1'b0, r_n};
    assign idx2      = {1'b0, r_i} + (CW+1)'(2);
    assign pop_addr  = r_base - FCW'(r_i) - FCW'(3);

    always_comb begin
        n_state    = r_state;
        n_qsize    = r_qsize;
        n_free     = r_free;
        n_base     = r_base;
        n_avail    = r_avail;
        n_cnt      = r_cnt;
        n_total    = r_total;
        n_rdbl     = r_rdbl;
        n_erd      = r_erd;
        n_n        = r_n;
        n_i        = r_i;
        n_head     = r_head;
        n_cur_desc = r_cur_desc;
        n_cur_ent  = r_cur_ent;
        n_strobe   = 1'b0;

        n_out             = '0;
        n_out.kind        = KIND_STATUS;
        n_out.avail_index = r_avail;
        n_out.last        = 1'b1;

        stk_init    = 1'b0;
        stk_wr_en   = 1'b0;
        stk_wr_addr = r_free[AW-1:0];
        stk_rd_en   = 1'b0;
        stk_rd_addr = '0;
        ch_wr_en    = 1'b0;
        ch_wr_idx   = r_cnt[IW-1:0];
        ch_rd_en    = 1'b0;
        ch_rd_idx   = '0;

        case (r_state)
            S_IDLE: begin
                if (cfg_wr) begin
                    n_qsize  = f_qsize(i_cfg_data);
                    n_free   = f_qsize(i_cfg_data);
                    n_avail  = '0;
                    n_cnt    = '0;
                    n_total  = '0;
                    n_rdbl   = '0;
                    stk_init = 1'b1;
                end else if (accept && (i_item.cmd == CMD_RETURN)) begin
                    n_strobe = 1'b1;
                    if (r_free >= r_qsize) begin
                        n_out.status = ST_OVERFLOW;
                    end else begin
                        stk_wr_en    = 1'b1;
                        n_free       = r_free + FCW'(1);
                        n_out.status = ST_OK;
                    end
                end else if (accept) begin
                    ch_wr_en = (32'(r_cnt) < MAX_CHAIN);
                    if (!i_item.chain_last) begin
                        n_cnt   = cnt_new;
                        n_total = total_new;
                        n_rdbl  = rd_eff;
                    end else begin
                        n_cnt   = '0;
                        n_total = '0;
                        n_rdbl  = '0;
                        if (32'(cnt_new) > MAX_CHAIN) begin
                            n_strobe     = 1'b1;
                            n_out.status = ST_TOO_LONG;
                        end else if (too_big) begin
                            n_strobe     = 1'b1;
                            n_out.status = ST_TOO_BIG;
                        end else if (32'(r_free) < 32'(cnt_new)) begin
                            n_strobe     = 1'b1;
                            n_out.status = ST_NO_FREE;
                        end else begin
                            n_n     = cnt_new;
                            n_i     = '0;
                            n_erd   = rd_eff;
                            n_base  = r_free;
                            n_free  = r_free - FCW'(cnt_new);
                            n_state = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                stk_rd_en   = 1'b1;
                stk_rd_addr = AW'(r_base - FCW'(1));
                ch_rd_en    = 1'b1;
                ch_rd_idx   = '0;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                n_cur_desc = stk_rd_data;
                n_head     = stk_rd_data;
                n_cur_ent  = ch_rd_data;
                if (r_n > CW'(1)) begin
                    stk_rd_en   = 1'b1;
                    stk_rd_addr = AW'(r_base - FCW'(2));
                    ch_rd_en    = 1'b1;
                    ch_rd_idx   = IW'(1);
                end
                n_state = S_DESC;
            end
            S_DESC: begin
                n_strobe          = 1'b1;
                n_out.kind        = KIND_DESC;
                n_out.slot        = r_cur_desc;
                n_out.addr        = r_cur_ent.addr;
                n_out.len         = r_cur_ent.len;
                n_out.flags[1]    = (32'(r_i) >= 32'(r_erd));
                n_out.flags[0]    = has_next;
                n_out.next_slot   = has_next ? stk_rd_data : '0;
                n_out.status      = ST_OK;
                n_out.last        = 1'b0;
                n_cur_desc        = stk_rd_data;
                n_cur_ent         = ch_rd_data;
                if (idx2 < {1'b0, r_n}) begin
                    stk_rd_en   = 1'b1;
                    stk_rd_addr = pop_addr[AW-1:0];
                    ch_rd_en    = 1'b1;
                    ch_rd_idx   = idx2[IW-1:0];
                end
                n_i = r_i + CW'(1);
                if (!has_next) begin
                    n_state = S_RING;
                end
            end
            S_RING: begin
                n_strobe          = 1'b1;
                n_out.kind        = KIND_RING;
                n_out.slot        = DESC_W'(r_avail & (AVAIL_W'(r_qsize) - AVAIL_W'(1)));
                n_out.addr        = ADDR_W'(r_head);
                n_out.avail_index = r_avail + AVAIL_W'(1);
                n_out.status      = ST_OK;
                n_avail           = r_avail + AVAIL_W'(1);
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_qsize  <= f_qsize(CFG_RESET);
            r_free   <= f_qsize(CFG_RESET);
            r_avail  <= '0;
            r_cnt    <= '0;
            r_total  <= '0;
            r_rdbl   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_qsize  <= n_qsize;
            r_free   <= n_free;
            r_avail  <= n_avail;
            r_cnt    <= n_cnt;
            r_total  <= n_total;
            r_rdbl   <= n_rdbl;
            r_strobe <= n_strobe;
        end
        r_base     <= n_base;
        r_erd      <= n_erd;
        r_n        <= n_n;
        r_i        <= n_i;
        r_head     <= n_head;
        r_cur_desc <= n_cur_desc;
        r_cur_ent  <= n_cur_ent;
        r_out      <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    vqcb_free_stack #(
        .MAX_QUEUE (MAX_QUEUE)
    ) u_free_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_init    (stk_init),
        .i_wr_en   (stk_wr_en),
        .i_wr_addr (stk_wr_addr),
        .i_wr_data (stk_wr_data),
        .i_rd_en   (stk_rd_en),
        .i_rd_addr (stk_rd_addr),
        .o_rd_data (stk_rd_data)
    );

    vqcb_chain_mem #(
        .MAX_CHAIN (MAX_CHAIN)
    ) u_chain_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (ch_wr_en),
        .i_wr_idx  (ch_wr_idx),
        .i_wr_data (ch_wr_data),
        .i_rd_en   (ch_rd_en),
        .i_rd_idx  (ch_rd_idx),
        .o_rd_data (ch_rd_data)
    );

    `VQCB_ASSERT(a_free_in_range, i_clk, i_rst_n, r_free <= r_qsize, "free count above queue size")
    `VQCB_ASSERT(a_desc_in_chain, i_clk, i_rst_n, (r_state == S_DESC) |-> (r_i < r_n), "descriptor past chain end")
    `VQCB_ASSERT(a_ring_ends_chain, i_clk, i_rst_n, (r_state == S_RING) |=> (o_strobe && o_result.last), "ring write not final")

endmodule
